[hdl/hsf_pkg.sv]
// ----------------------------------------------------------------------------
// hsf_pkg
// Shared types and constants for the scaled forward step unit.
// ----------------------------------------------------------------------------
package hsf_pkg;

  // Probability format, fixed by the field widths of the interface.
  localparam int PROB_BITS = 16;
  localparam int WIDE_BITS = PROB_BITS + 2;

  // Default model size.
  localparam int DEF_NUM_STATES  = 4;
  localparam int DEF_NUM_SYMBOLS = 8;

  // Interface field widths.
  localparam int ACTION_W    = 2;
  localparam int SYMBOL_W    = 3;
  localparam int ROW_W       = 3;
  localparam int COL_W       = 2;
  localparam int STATE_IDX_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_OBSERVE    = 2'd0,
    ACT_LOAD_TRANS = 2'd1,
    ACT_LOAD_EMIT  = 2'd2,
    ACT_LOAD_INIT  = 2'd3
  } action_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // input transfer: latch the item, write a table on loads
    logic tr_mul;     // forward(j) times transition(j, i)
    logic acc_add;    // add the rounded transition term
    logic base_load;  // select the base value for state i
    logic em_mul;     // base times emission
    logic u_store;    // round, store the unscaled value, add it to the sum
    logic div_init;   // start normalizing state i
    logic div_step;   // one quotient bit
    logic out_load;   // fill the output register
  } hsf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start;       // current observation opens a sequence
    logic div_bypass;  // zero sum or saturating quotient, no iterations needed
  } hsf_stat_t;

endpackage

[hdl/hsf_ram.sv]
// ----------------------------------------------------------------------------
// hsf_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module hsf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/hsf_datapath.sv]
// ----------------------------------------------------------------------------
// hsf_datapath
// Tables, forward vector, multiply-accumulate path and serial divider.
// ----------------------------------------------------------------------------
module hsf_datapath
  import hsf_pkg::*;
#(
  parameter int NUM_STATES  = DEF_NUM_STATES,
  parameter int NUM_SYMBOLS = DEF_NUM_SYMBOLS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hsf_cmd_t                      cmd_i,
  output hsf_stat_t                     stat_o,
  input  logic [$clog2(NUM_STATES)-1:0] dst_idx_i,
  input  logic [$clog2(NUM_STATES)-1:0] src_idx_i,
  input  logic [ACTION_W-1:0]           action_i,
  input  logic                          sequence_start_i,
  input  logic [SYMBOL_W-1:0]           symbol_i,
  input  logic [ROW_W-1:0]              table_row_i,
  input  logic [COL_W-1:0]              table_col_i,
  input  logic [PROB_BITS-1:0]          prob_value_i,
  output logic [STATE_IDX_W-1:0]        state_index_o,
  output logic [PROB_BITS-1:0]          forward_prob_o,
  output logic [WIDE_BITS-1:0]          scale_sum_o,
  output logic                          zero_sum_error_o,
  output logic                          last_of_run_o
);

  localparam int SI_W     = $clog2(NUM_STATES);
  localparam int TR_DEPTH = NUM_STATES * NUM_STATES;
  localparam int TR_AW    = $clog2(TR_DEPTH);
  localparam int EM_DEPTH = NUM_SYMBOLS * NUM_STATES;
  localparam int EM_AW    = $clog2(EM_DEPTH);
  localparam int ACC_W    = PROB_BITS + SI_W + 1;
  localparam int SUM_W    = WIDE_BITS + SI_W;
  localparam int PROD_W   = 2 * PROB_BITS;
  localparam int UPROD_W  = WIDE_BITS + PROB_BITS;
  localparam logic [31:0]          WIDE_MAX = 32'((64'd1 << WIDE_BITS) - 64'd1);
  localparam logic [PROB_BITS-1:0] PROB_MAX = '1;
  localparam logic [SI_W-1:0]      LAST_IDX = SI_W'(NUM_STATES - 1);

  action_e act;
  logic tr_we, em_we, init_we;
  logic [TR_AW-1:0] tr_waddr, tr_raddr;
  logic [EM_AW-1:0] em_waddr, em_raddr;
  logic [PROB_BITS-1:0] tr_rdata, em_rdata, em_val;

  logic                  start_q, sym_ok_q;
  logic [SYMBOL_W-1:0]   sym_q;
  logic [PROD_W-1:0]     prod_q;
  logic [ACC_W-1:0]      acc_q;
  logic [WIDE_BITS-1:0]  base_q;
  logic [UPROD_W-1:0]    uprod_q;
  logic [SUM_W-1:0]      sum_q;
  logic [PROB_BITS-1:0]  init_q [NUM_STATES];
  logic [PROB_BITS-1:0]  fwd_q  [NUM_STATES];
  logic [WIDE_BITS-1:0]  uns_q  [NUM_STATES];
  logic [SUM_W-1:0]      rem_q;
  logic [PROB_BITS-1:0]  quo_q;
  logic                  bypass_q;

  logic [PROD_W:0]       prod_rnd;
  logic [UPROD_W:0]      uprod_rnd;
  logic [WIDE_BITS:0]    u_raw;
  logic [WIDE_BITS-1:0]  u_sat;
  logic [SUM_W:0]        rem_sh, den_ext;
  logic                  sum_zero, bypass, rnd_up;
  logic [PROB_BITS-1:0]  f_val;

  assign act = action_e'(action_i);

  // Table writes; out of range rows and columns are dropped.
  assign tr_we = cmd_i.capture && (act == ACT_LOAD_TRANS) &&
                 (32'(table_row_i) < NUM_STATES) && (32'(table_col_i) < NUM_STATES);
  assign em_we = cmd_i.capture && (act == ACT_LOAD_EMIT) &&
                 (32'(table_row_i) < NUM_SYMBOLS) && (32'(table_col_i) < NUM_STATES);
  assign init_we = cmd_i.capture && (act == ACT_LOAD_INIT) &&
                   (32'(table_row_i) < NUM_STATES);

  assign tr_waddr = TR_AW'(32'(table_row_i) * NUM_STATES + 32'(table_col_i));
  assign em_waddr = EM_AW'(32'(table_row_i) * NUM_STATES + 32'(table_col_i));
  assign tr_raddr = TR_AW'(32'(src_idx_i) * NUM_STATES + 32'(dst_idx_i));
  assign em_raddr = EM_AW'(32'(sym_q) * NUM_STATES + 32'(dst_idx_i));

  hsf_ram #(.WIDTH(PROB_BITS), .DEPTH(TR_DEPTH)) u_tr_ram (
    .clk_i   (clk_i),
    .we_i    (tr_we),
    .waddr_i (tr_waddr),
    .wdata_i (prob_value_i),
    .raddr_i (tr_raddr),
    .rdata_o (tr_rdata)
  );

  hsf_ram #(.WIDTH(PROB_BITS), .DEPTH(EM_DEPTH)) u_em_ram (
    .clk_i   (clk_i),
    .we_i    (em_we),
    .waddr_i (em_waddr),
    .wdata_i (prob_value_i),
    .raddr_i (em_raddr),
    .rdata_o (em_rdata)
  );

  assign em_val = sym_ok_q ? em_rdata : '0;

  // Rounding of the products to the probability grid.
  assign prod_rnd  = {1'b0, prod_q} + (PROD_W + 1)'(1 << (PROB_BITS - 1));
  assign uprod_rnd = {1'b0, uprod_q} + (UPROD_W + 1)'(1 << (PROB_BITS - 1));
  assign u_raw     = uprod_rnd[UPROD_W:PROB_BITS];
  assign u_sat     = u_raw[WIDE_BITS] ? WIDE_BITS'(WIDE_MAX) : u_raw[WIDE_BITS-1:0];

  // Divider support.
  assign den_ext  = {1'b0, sum_q};
  assign rem_sh   = {rem_q, 1'b0};
  assign sum_zero = (sum_q == '0);
  assign bypass   = sum_zero || (SUM_W'(uns_q[dst_idx_i]) >= sum_q);
  assign rnd_up   = (rem_sh >= den_ext);

  always_comb begin
    if (sum_zero) begin
      f_val = '0;
    end else if (bypass_q) begin
      f_val = PROB_MAX;
    end else if (rnd_up && (quo_q != PROB_MAX)) begin
      f_val = quo_q + PROB_BITS'(1);
    end else begin
      f_val = quo_q;
    end
  end

  assign stat_o.start      = start_q;
  assign stat_o.div_bypass = bypass;

  always_ff @(posedge clk_i) begin
    if (init_we) begin
      init_q[SI_W'(table_row_i)] <= prob_value_i;
    end
    if (cmd_i.capture) begin
      start_q  <= sequence_start_i;
      sym_q    <= symbol_i;
      sym_ok_q <= (32'(symbol_i) < NUM_SYMBOLS);
    end
    if (cmd_i.tr_mul) begin
      prod_q <= PROD_W'(fwd_q[src_idx_i]) * PROD_W'(tr_rdata);
    end
    if (cmd_i.capture || cmd_i.u_store) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + ACC_W'(prod_rnd[PROD_W:PROB_BITS]);
    end
    if (cmd_i.base_load) begin
      if (start_q) begin
        base_q <= WIDE_BITS'(init_q[dst_idx_i]);
      end else if (32'(acc_q) > WIDE_MAX) begin
        base_q <= WIDE_BITS'(WIDE_MAX);
      end else begin
        base_q <= WIDE_BITS'(acc_q);
      end
    end
    if (cmd_i.em_mul) begin
      uprod_q <= UPROD_W'(base_q) * UPROD_W'(em_val);
    end
    if (cmd_i.capture) begin
      sum_q <= '0;
    end else if (cmd_i.u_store) begin
      sum_q <= sum_q + SUM_W'(u_sat);
    end
    if (cmd_i.div_init) begin
      rem_q    <= SUM_W'(uns_q[dst_idx_i]);
      quo_q    <= '0;
      bypass_q <= bypass;
    end else if (cmd_i.div_step) begin
      if (rem_sh >= den_ext) begin
        rem_q <= SUM_W'(rem_sh - den_ext);
        quo_q <= {quo_q[PROB_BITS-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[SUM_W-1:0];
        quo_q <= {quo_q[PROB_BITS-2:0], 1'b0};
      end
    end
    if (cmd_i.out_load) begin
      state_index_o    <= STATE_IDX_W'(dst_idx_i);
      forward_prob_o   <= f_val;
      scale_sum_o      <= (32'(sum_q) > WIDE_MAX) ? WIDE_BITS'(WIDE_MAX)
                                                   : WIDE_BITS'(sum_q);
      zero_sum_error_o <= sum_zero;
      last_of_run_o    <= (dst_idx_i == LAST_IDX);
    end
  end

  // Forward and unscaled vectors have a defined reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_STATES; s++) begin
        fwd_q[s] <= '0;
        uns_q[s] <= '0;
      end
    end else begin
      if (cmd_i.u_store) begin
        uns_q[dst_idx_i] <= u_sat;
      end
      if (cmd_i.out_load) begin
        fwd_q[dst_idx_i] <= f_val;
      end
    end
  end

endmodule

[hdl/hsf_ctrl.sv]
// ----------------------------------------------------------------------------
// hsf_ctrl
// Sequencer for one observation: accumulate, scale, divide, emit.
// ----------------------------------------------------------------------------
module hsf_ctrl
  import hsf_pkg::*;
#(
  parameter int NUM_STATES = DEF_NUM_STATES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ACTION_W-1:0]           action_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output hsf_cmd_t                      cmd_o,
  input  hsf_stat_t                     stat_i,
  output logic [$clog2(NUM_STATES)-1:0] dst_idx_o,
  output logic [$clog2(NUM_STATES)-1:0] src_idx_o
);

  localparam int SI_W = $clog2(NUM_STATES);
  localparam int K_W  = $clog2(PROB_BITS);
  localparam logic [SI_W-1:0] LAST_IDX = SI_W'(NUM_STATES - 1);
  localparam logic [K_W-1:0]  LAST_K   = K_W'(PROB_BITS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ISSUE, S_MUL, S_ACC, S_EMRD, S_EMMUL, S_STORE, S_DIVST, S_DIV, S_OUT
  } state_e;

  state_e          state_q;
  logic [SI_W-1:0] i_q, j_q;
  logic [K_W-1:0]  k_q;
  logic            out_valid_q;
  logic            in_xfer, slot_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign dst_idx_o  = i_q;
  assign src_idx_o  = j_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.capture   = in_xfer;
    cmd_o.tr_mul    = (state_q == S_MUL);
    cmd_o.acc_add   = (state_q == S_ACC);
    cmd_o.base_load = (state_q == S_EMRD);
    cmd_o.em_mul    = (state_q == S_EMMUL);
    cmd_o.u_store   = (state_q == S_STORE);
    cmd_o.div_init  = (state_q == S_DIVST);
    cmd_o.div_step  = (state_q == S_DIV);
    cmd_o.out_load  = (state_q == S_OUT) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          i_q <= '0;
          j_q <= '0;
          if (in_xfer && (action_e'(action_i) == ACT_OBSERVE)) begin
            state_q <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          state_q <= stat_i.start ? S_EMRD : S_MUL;
        end
        S_MUL: begin
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (j_q == LAST_IDX) begin
            j_q     <= '0;
            state_q <= S_EMRD;
          end else begin
            j_q     <= j_q + SI_W'(1);
            state_q <= S_ISSUE;
          end
        end
        S_EMRD: begin
          state_q <= S_EMMUL;
        end
        S_EMMUL: begin
          state_q <= S_STORE;
        end
        S_STORE: begin
          if (i_q == LAST_IDX) begin
            i_q     <= '0;
            state_q <= S_DIVST;
          end else begin
            i_q     <= i_q + SI_W'(1);
            state_q <= S_ISSUE;
          end
        end
        S_DIVST: begin
          k_q     <= '0;
          state_q <= stat_i.div_bypass ? S_OUT : S_DIV;
        end
        S_DIV: begin
          k_q <= k_q + K_W'(1);
          if (k_q == LAST_K) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (slot_free) begin
            if (i_q == LAST_IDX) begin
              state_q <= S_IDLE;
            end else begin
              i_q     <= i_q + SI_W'(1);
              state_q <= S_DIVST;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hdl/hmm_scaled_forward_step_unit.sv]
// ----------------------------------------------------------------------------
// hmm_scaled_forward_step_unit
// Scaled forward recursion of a hidden Markov model, one symbol per item.
// ----------------------------------------------------------------------------
// Load items produce no transfer on the output channel. An observe item
// builds the unscaled vector, from the initial table on a sequence start
// and from the transition terms otherwise, then normalizes it in the
// shared restoring divider, which retires one quotient bit per cycle.
// Reset is asynchronous and active low; it clears the sequencer, the output
// valid and the forward and unscaled vectors. The tables hold no reset value.
// ----------------------------------------------------------------------------
module hmm_scaled_forward_step_unit
  import hsf_pkg::*;
#(
  parameter int NUM_STATES  = DEF_NUM_STATES,
  parameter int NUM_SYMBOLS = DEF_NUM_SYMBOLS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input channel.
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [ACTION_W-1:0]    action_i,
  input  logic                   sequence_start_i,
  input  logic [SYMBOL_W-1:0]    symbol_i,
  input  logic [ROW_W-1:0]       table_row_i,
  input  logic [COL_W-1:0]       table_col_i,
  input  logic [PROB_BITS-1:0]   prob_value_i,
  // Output channel, one transfer per hidden state.
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [STATE_IDX_W-1:0] state_index_o,
  output logic [PROB_BITS-1:0]   forward_prob_o,
  output logic [WIDE_BITS-1:0]   scale_sum_o,
  output logic                   zero_sum_error_o,
  output logic                   last_of_run_o
);

  localparam int SI_W = $clog2(NUM_STATES);

  hsf_cmd_t        cmd;
  hsf_stat_t       stat;
  logic [SI_W-1:0] dst_idx, src_idx;

  // The controller walks destination state i and source state j; the
  // datapath does the arithmetic. The output register lets a finished
  // result wait for the consumer while the controller keeps dividing.
  hsf_ctrl #(.NUM_STATES(NUM_STATES)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat),
    .dst_idx_o   (dst_idx),
    .src_idx_o   (src_idx)
  );

  // Products are rounded to the probability grid before they are summed,
  // and the normalized values are rounded half up and saturate.
  hsf_datapath #(
    .NUM_STATES  (NUM_STATES),
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .dst_idx_i        (dst_idx),
    .src_idx_i        (src_idx),
    .action_i         (action_i),
    .sequence_start_i (sequence_start_i),
    .symbol_i         (symbol_i),
    .table_row_i      (table_row_i),
    .table_col_i      (table_col_i),
    .prob_value_i     (prob_value_i),
    .state_index_o    (state_index_o),
    .forward_prob_o   (forward_prob_o),
    .scale_sum_o      (scale_sum_o),
    .zero_sum_error_o (zero_sum_error_o),
    .last_of_run_o    (last_of_run_o)
  );

endmodule

[hdl/hsf_checker.sv]
// ----------------------------------------------------------------------------
// hsf_checker
// Port level checks for the scaled forward step unit.
// ----------------------------------------------------------------------------
module hsf_checker
  import hsf_pkg::*;
#(
  parameter int NUM_STATES = DEF_NUM_STATES
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [STATE_IDX_W-1:0] state_index_o,
  input logic [PROB_BITS-1:0]   forward_prob_o,
  input logic [WIDE_BITS-1:0]   scale_sum_o,
  input logic                   zero_sum_error_o,
  input logic                   last_of_run_o
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(forward_prob_o))
    else $error("output changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_sum_error_o |-> forward_prob_o == '0 && scale_sum_o == '0)
    else $error("zero sum result carries nonzero data");

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_run_o |-> state_index_o == STATE_IDX_W'(NUM_STATES - 1))
    else $error("last flag on wrong state");

  // While a result other than the last one is shown, the run is not over.
  a_busy_midrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> !in_ready_o)
    else $error("input accepted in the middle of a run");

endmodule

bind hmm_scaled_forward_step_unit hsf_checker #(.NUM_STATES(NUM_STATES)) u_hsf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .state_index_o    (state_index_o),
  .forward_prob_o   (forward_prob_o),
  .scale_sum_o      (scale_sum_o),
  .zero_sum_error_o (zero_sum_error_o),
  .last_of_run_o    (last_of_run_o)
);

[dv/hmm_scaled_forward_step_unit_test.sv]
// ----------------------------------------------------------------------------
// hmm_scaled_forward_step_unit_test
// Self-checking bench for the scaled forward step unit.
// ----------------------------------------------------------------------------
// The bench first fills every table entry, so no unwritten entry is ever read.
// It then walks a short table of directed items and sends a random mix of
// loads and observations. A local model tracks the tables and the forward
// vector. For each accepted observation it queues the four per-state results.
// Each output transfer is checked field by field against the oldest queued
// result. Both channels idle in several phases of varying density.
// ----------------------------------------------------------------------------
module hmm_scaled_forward_step_unit_test;
  import hsf_pkg::*;

  localparam int NST = DEF_NUM_STATES;
  localparam int NSYM = DEF_NUM_SYMBOLS;
  localparam logic [63:0] PMAX = 64'd65535;
  localparam logic [63:0] WMAX = 64'd262143;
  localparam logic [63:0] HALF = 64'd32768;
  localparam int STALL_LIMIT = 5000;
  localparam int N_RANDOM = 94;

  // One input item, plus optional hand-computed results for the directed rows.
  typedef struct {
    action_e     act;
    logic        start;
    logic [2:0]  sym;
    logic [2:0]  row;
    logic [1:0]  col;
    logic [15:0] val;
    bit          typed;
    logic        t_err;
    logic [15:0] t_prob;
    logic [17:0] t_sum;
  } hmm_item_t;

  // One per-state result as the output channel carries it.
  typedef struct {
    logic [1:0]  state;
    logic [15:0] prob;
    logic [17:0] sum;
    logic        err;
    logic        last;
  } state_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [ACTION_W-1:0] action_i = ACT_OBSERVE;
  logic sequence_start_i = 1'b0;
  logic [SYMBOL_W-1:0] symbol_i = '0;
  logic [ROW_W-1:0] table_row_i = '0;
  logic [COL_W-1:0] table_col_i = '0;
  logic [PROB_BITS-1:0] prob_value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [STATE_IDX_W-1:0] state_index_o;
  logic [PROB_BITS-1:0] forward_prob_o;
  logic [WIDE_BITS-1:0] scale_sum_o;
  logic zero_sum_error_o;
  logic last_of_run_o;

  // Local copy of the model state.
  logic [63:0] trans_tbl[NST*NST];
  logic [63:0] emit_tbl[NSYM*NST];
  logic [63:0] init_tbl[NST];
  logic [63:0] fwd_vec[NST];

  state_result_t pending_results[$];
  hmm_item_t directed_rows[$];
  int errors = 0;
  int idle_in_pct = 0;
  int stall_out_pct = 0;
  int quiet_cycles = 0;

  hmm_scaled_forward_step_unit dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Builds one item; the typed fields stay clear for predictor-checked rows.
  function automatic hmm_item_t mk(action_e act, logic start, int sym, int row, int col,
                                   int val);
    hmm_item_t it;
    it.act = act;
    it.start = start;
    it.sym = sym[2:0];
    it.row = row[2:0];
    it.col = col[1:0];
    it.val = val[15:0];
    it.typed = 1'b0;
    it.t_err = 1'b0;
    it.t_prob = '0;
    it.t_sum = '0;
    return it;
  endfunction

  // round(num * 2^16 / den) half up, saturating at the Q0.16 maximum.
  function automatic logic [63:0] normalize(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    if (num >= den) return PMAX;
    q = ((num << 17) + den) / (den << 1);
    return (q > PMAX) ? PMAX : q;
  endfunction

  // Applies one accepted item to the local state and queues its results.
  task automatic forward_update(hmm_item_t it);
    logic [63:0] unscaled[NST];
    logic [63:0] total;
    logic [63:0] base;
    logic [63:0] em;
    logic [63:0] u;
    state_result_t r;
    total = 0;
    case (it.act)
      ACT_LOAD_TRANS: begin
        if (it.row < NST) trans_tbl[it.row*NST+it.col] = 64'(it.val);
      end
      ACT_LOAD_EMIT: begin
        if (it.row < NSYM) emit_tbl[it.row*NST+it.col] = 64'(it.val);
      end
      ACT_LOAD_INIT: begin
        if (it.row < NST) init_tbl[it.row] = 64'(it.val);
      end
      default: begin
        for (int i = 0; i < NST; i++) begin
          em = (it.sym < NSYM) ? emit_tbl[it.sym*NST+i] : 64'd0;
          if (it.start) begin
            base = init_tbl[i];
          end else begin
            base = 0;
            // Each transition term is rounded before it is summed.
            for (int j = 0; j < NST; j++)
              base += (fwd_vec[j] * trans_tbl[j*NST+i] + HALF) >> 16;
            if (base > WMAX) base = WMAX;
          end
          u = (base * em + HALF) >> 16;
          if (u > WMAX) u = WMAX;
          unscaled[i] = u;
          total += u;
        end
        for (int i = 0; i < NST; i++) begin
          fwd_vec[i] = (total == 0) ? 64'd0 : normalize(unscaled[i], total);
          r.state = i[1:0];
          r.prob = fwd_vec[i][15:0];
          r.sum = (total > WMAX) ? WMAX[17:0] : total[17:0];
          r.err = (total == 0);
          r.last = (i == NST - 1);
          // Directed rows with hand-computed results override the prediction.
          if (it.typed) begin
            r.prob = it.t_prob;
            r.sum = it.t_sum;
            r.err = it.t_err;
          end
          pending_results.push_back(r);
        end
      end
    endcase
  endtask

  // Presents one item and returns at the edge where it is accepted.
  task automatic send_item(hmm_item_t it);
    if (idle_in_pct > 0 && $urandom_range(99) < idle_in_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_in_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= it.act;
    sequence_start_i <= it.start;
    symbol_i <= it.sym;
    table_row_i <= it.row;
    table_col_i <= it.col;
    prob_value_i <= it.val;
    do @(posedge clk_i); while (!in_ready_o);
    forward_update(it);
  endtask

  function automatic int rand_prob();
    int pick;
    pick = $urandom_range(7);
    if (pick == 0) return 0;
    if (pick == 1) return 65535;
    return $urandom_range(65535);
  endfunction

  // Output side: check each transfer, then choose the next ready value.
  always @(posedge clk_i) begin
    state_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected output transfer for state %0d", state_index_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (state_index_o !== want.state) begin
          $error("state_index: expected %0d, got %0d", want.state, state_index_o);
          errors++;
        end
        if (forward_prob_o !== want.prob) begin
          $error("forward_prob: expected %0d, got %0d", want.prob, forward_prob_o);
          errors++;
        end
        if (scale_sum_o !== want.sum) begin
          $error("scale_sum: expected %0d, got %0d", want.sum, scale_sum_o);
          errors++;
        end
        if (zero_sum_error_o !== want.err) begin
          $error("zero_sum_error: expected %0d, got %0d", want.err, zero_sum_error_o);
          errors++;
        end
        if (last_of_run_o !== want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, last_of_run_o);
          errors++;
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= stall_out_pct);
  end

  // Watchdog: any transfer on either channel counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    hmm_item_t it;
    int pick;
    for (int i = 0; i < NST; i++) begin
      fwd_vec[i] = 0;
      init_tbl[i] = 0;
    end
    for (int i = 0; i < NST*NST; i++) trans_tbl[i] = 0;
    for (int i = 0; i < NSYM*NST; i++) emit_tbl[i] = 0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every table entry so later observations never read unwritten data.
    for (int r = 0; r < NST; r++)
      for (int c = 0; c < NST; c++)
        send_item(mk(ACT_LOAD_TRANS, 1'b0, 0, r, c, rand_prob()));
    for (int s = 0; s < NSYM; s++)
      for (int c = 0; c < NST; c++)
        send_item(mk(ACT_LOAD_EMIT, 1'b0, 0, s, c, $urandom_range(1, 65535)));
    for (int r = 0; r < NST; r++)
      send_item(mk(ACT_LOAD_INIT, 1'b0, 0, r, 0, $urandom_range(1, 65535)));

    // Directed rows. A symbol with zero emission gives a zero scale sum,
    // and a continuation from that all-zero vector stays in error.
    for (int c = 0; c < NST; c++) directed_rows.push_back(mk(ACT_LOAD_EMIT, 0, 0, 7, c, 0));
    it = mk(ACT_OBSERVE, 1'b1, 7, 0, 0, 0);
    it.typed = 1'b1;
    it.t_err = 1'b1;
    directed_rows.push_back(it);
    it = mk(ACT_OBSERVE, 1'b0, 0, 0, 0, 0);
    it.typed = 1'b1;
    it.t_err = 1'b1;
    directed_rows.push_back(it);
    // Loads beyond the table size must leave the tables untouched.
    directed_rows.push_back(mk(ACT_LOAD_TRANS, 1'b0, 0, 5, 1, 1234));
    directed_rows.push_back(mk(ACT_LOAD_INIT, 1'b0, 0, 6, 3, 777));
    // Full-scale initial and emission values give the largest scale sum of a sequence start.
    for (int r = 0; r < NST; r++) directed_rows.push_back(mk(ACT_LOAD_INIT, 0, 0, r, 0, 65535));
    for (int c = 0; c < NST; c++) directed_rows.push_back(mk(ACT_LOAD_EMIT, 0, 0, 6, c, 65535));
    directed_rows.push_back(mk(ACT_OBSERVE, 1'b1, 6, 0, 0, 0));
    directed_rows.push_back(mk(ACT_OBSERVE, 1'b0, 6, 0, 0, 0));
    // A single live state normalizes to the saturated maximum.
    for (int c = 0; c < NST; c++)
      directed_rows.push_back(mk(ACT_LOAD_EMIT, 0, 0, 5, c, (c == 0) ? 65535 : 0));
    directed_rows.push_back(mk(ACT_OBSERVE, 1'b0, 5, 0, 0, 0));
    directed_rows.push_back(mk(ACT_OBSERVE, 1'b1, 3, 0, 0, 0));
    foreach (directed_rows[k]) send_item(directed_rows[k]);

    // Random mix in four idling phases: none, sender idle, receiver stalls, both.
    for (int n = 0; n < N_RANDOM; n++) begin
      case (n * 4 / N_RANDOM)
        0: begin idle_in_pct = 0; stall_out_pct = 0; end
        1: begin idle_in_pct = 83; stall_out_pct = 0; end
        2: begin idle_in_pct = 0; stall_out_pct = 83; end
        default: begin idle_in_pct = 34; stall_out_pct = 34; end
      endcase
      pick = $urandom_range(9);
      if (pick < 6) begin
        it = mk(ACT_OBSERVE, ($urandom_range(3) == 0), $urandom_range(7), 0, 0, 0);
        it.row = 3'($urandom);
        it.col = 2'($urandom);
        it.val = 16'($urandom);
      end else begin
        it = mk(action_e'(2'($urandom_range(1, 3))), 1'($urandom_range(1)),
                $urandom_range(7), $urandom_range(7), $urandom_range(3), rand_prob());
      end
      send_item(it);
    end
    in_valid_i <= 1'b0;
    idle_in_pct = 0;
    stall_out_pct = 0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
